FILE: hw/rtl/ccvr_pkg.sv
package ccvr_pkg;

  // field and datapath widths
  localparam int FIELD_W  = 32;
  localparam int XY_W     = 36;
  localparam int Z_W      = 34;
  localparam int PROD_W   = XY_W + FIELD_W;
  localparam int STAGES_DEFAULT = 16;
  localparam int STAGES_MAX     = 30;

  // angles in q4.30 radians
  localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  // register indexes
  localparam logic CFG_TO_CYL   = 1'b0;
  localparam logic CFG_PTS_CART = 1'b1;

  // payload travelling down the rotation stages
  typedef struct packed {
    logic                    use_z;
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [Z_W-1:0]   z;
    logic signed [XY_W-1:0]  a;
    logic signed [XY_W-1:0]  b;
    logic [FIELD_W-1:0]      c;
    logic                    last;
  } work_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = 34'sd1 <<< (30 - i);
    endcase
    return r;
  endfunction

  // gain compensation in q30, elaboration time only
  function automatic logic [31:0] gain_q30(input int n);
    logic [63:0]  p;
    logic [63:0]  f;
    logic [63:0]  k2;
    logic [127:0] rem;
    logic [63:0]  v;
    logic [63:0]  res;
    logic [63:0]  bitv;
    p = 64'd1 << 30;
    for (int i = 0; i < n; i++) begin
      f = 64'd1 << 30;
      if (2 * i <= 30) f = f + (64'd1 << (30 - 2 * i));
      p = 64'((128'(p) * 128'(f)) >> 30);
    end
    // restoring long division of 2^60 by p
    k2  = '0;
    rem = '0;
    for (int j = 60; j >= 0; j--) begin
      rem = {rem[126:0], (j == 60) ? 1'b1 : 1'b0};
      if (rem >= 128'(p)) begin
        rem = rem - 128'(p);
        k2[j] = 1'b1;
      end
    end
    // integer square root of k2 * 2^30
    v    = k2 << 30;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

endpackage

FILE: hw/rtl/ccvr_pre.sv
module ccvr_pre (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              pts_cart,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] point_first,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] point_second,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] vec_a,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] vec_b,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] vec_c,
  input  logic                              last_point,
  output ccvr_pkg::work_t                   q
);

  localparam int ZWIDE = ccvr_pkg::FIELD_W + 14;

  logic                                 origin;
  logic                                 neg;
  logic signed [ZWIDE-1:0]              zw;
  logic signed [ccvr_pkg::Z_W-1:0]      zs;
  logic signed [ccvr_pkg::Z_W-1:0]      zf;
  logic signed [ccvr_pkg::XY_W-1:0]     px;
  logic signed [ccvr_pkg::XY_W-1:0]     py;
  logic signed [ccvr_pkg::XY_W-1:0]     va;
  logic signed [ccvr_pkg::XY_W-1:0]     vb;
  ccvr_pkg::work_t                      d;

  // azimuth scaling, saturation and folding into half plane
  always_comb begin
    origin = (point_first == '0) && (point_second == '0);
    zw = {point_second, 14'b0};
    if (zw > ZWIDE'(ccvr_pkg::PI_Q30)) zs = ccvr_pkg::PI_Q30;
    else if (zw < -ZWIDE'(ccvr_pkg::PI_Q30)) zs = -ccvr_pkg::PI_Q30;
    else zs = ccvr_pkg::Z_W'(zw);
    px = ccvr_pkg::XY_W'(point_first);
    py = ccvr_pkg::XY_W'(point_second);
    va = ccvr_pkg::XY_W'(vec_a);
    vb = ccvr_pkg::XY_W'(vec_b);
    zf = zs;
    neg = 1'b0;
    if (pts_cart) begin
      zf = '0;
      if (!origin && point_first[ccvr_pkg::FIELD_W-1]) begin
        neg = 1'b1;
        px  = -px;
        py  = -py;
      end
    end else if (zs > ccvr_pkg::HALF_PI_Q30) begin
      neg = 1'b1;
      zf  = zs - ccvr_pkg::PI_Q30;
    end else if (zs < -ccvr_pkg::HALF_PI_Q30) begin
      neg = 1'b1;
      zf  = zs + ccvr_pkg::PI_Q30;
    end
    d.use_z = !pts_cart || origin;
    d.x     = px;
    d.y     = py;
    d.z     = zf;
    d.a     = neg ? -va : va;
    d.b     = neg ? -vb : vb;
    d.c     = vec_c;
    d.last  = last_point;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (en) q <= d;
  end

endmodule

FILE: hw/rtl/ccvr_stage.sv
module ccvr_stage #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic            to_cyl,
  input  ccvr_pkg::work_t d,
  output ccvr_pkg::work_t q
);

  localparam logic signed [ccvr_pkg::Z_W-1:0] ATAN = ccvr_pkg::atan_q30(IDX);

  logic            sig;
  logic            rot_pos;
  ccvr_pkg::work_t n;

  // one micro-rotation of point and vector; the vector direction comes from the z or y sign and to_cyl
  always_comb begin
    n = d;
    sig = d.use_z ? !d.z[ccvr_pkg::Z_W-1] : !d.y[ccvr_pkg::XY_W-1];
    if (!d.y[ccvr_pkg::XY_W-1]) begin
      n.x = d.x + (d.y >>> IDX);
      n.y = d.y - (d.x >>> IDX);
    end else begin
      n.x = d.x - (d.y >>> IDX);
      n.y = d.y + (d.x >>> IDX);
    end
    n.z = d.z[ccvr_pkg::Z_W-1] ? d.z + ATAN : d.z - ATAN;
    rot_pos = sig ^ to_cyl;
    if (rot_pos) begin
      n.a = d.a - (d.b >>> IDX);
      n.b = d.b + (d.a >>> IDX);
    end else begin
      n.a = d.a + (d.b >>> IDX);
      n.b = d.b - (d.a >>> IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= n;
  end

endmodule

FILE: hw/rtl/ccvr_finish.sv
module ccvr_finish #(
  parameter int ANGLE_STAGES = ccvr_pkg::STAGES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                en_mul,
  input  logic                                en_out,
  input  ccvr_pkg::work_t                     d,
  output logic signed [ccvr_pkg::FIELD_W-1:0] res_a,
  output logic signed [ccvr_pkg::FIELD_W-1:0] res_b,
  output logic signed [ccvr_pkg::FIELD_W-1:0] res_c,
  output logic                                last
);

  localparam int PW = ccvr_pkg::PROD_W;
  localparam int RW = PW - 30;
  localparam logic signed [ccvr_pkg::FIELD_W-1:0] GAIN =
    ccvr_pkg::FIELD_W'(ccvr_pkg::gain_q30(ANGLE_STAGES));

  logic signed [PW-1:0]               pa;
  logic signed [PW-1:0]               pb;
  logic [ccvr_pkg::FIELD_W-1:0]       c_mul;
  logic                               last_mul;
  logic signed [RW-1:0]               ra;
  logic signed [RW-1:0]               rb;

  // gain product
  always_ff @(posedge clk) begin
    if (en_mul) begin
      pa       <= d.a * GAIN;
      pb       <= d.b * GAIN;
      c_mul    <= d.c;
      last_mul <= d.last;
    end
  end

  function automatic logic signed [ccvr_pkg::FIELD_W-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [ccvr_pkg::FIELD_W-1:0] r;
    if (v > RW'(32'sh7fffffff)) r = 32'sh7fffffff;
    else if (v < -RW'(33'sh080000000)) r = 32'sh80000000;
    else r = ccvr_pkg::FIELD_W'(v);
    return r;
  endfunction

  // round to nearest and drop q30 scale
  always_comb begin
    ra = RW'((pa + (PW'(1) <<< 29)) >>> 30);
    rb = RW'((pb + (PW'(1) <<< 29)) >>> 30);
  end

  // output register
  always_ff @(posedge clk) begin
    if (en_out) begin
      res_a <= sat(ra);
      res_b <= sat(rb);
      res_c <= c_mul;
      last  <= last_mul;
    end
  end

endmodule

FILE: hw/rtl/cartesian_cylindrical_vector_rotate_unit.sv
// pipeline: ANGLE_STAGES + 3 register stages from the accepting edge to output valid
// (conditioning, one per angle stage, gain, output)
// throughput: one transaction per cycle while the output is not stalled, one micro-rotation register per angle stage
// each stage holds its transaction until the next stage has room, bubbles close up
// reset: synchronous, clears all stage valid bits and sets both configuration
// registers to 1 (cartesian to cylindrical, cartesian points)
module cartesian_cylindrical_vector_rotate_unit #(
  parameter int ANGLE_STAGES = ccvr_pkg::STAGES_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic                                cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] point_first,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] point_second,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] vec_a,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] vec_b,
  input  logic signed [ccvr_pkg::FIELD_W-1:0] vec_c,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ccvr_pkg::FIELD_W-1:0] res_a,
  output logic signed [ccvr_pkg::FIELD_W-1:0] res_b,
  output logic signed [ccvr_pkg::FIELD_W-1:0] res_c,
  output logic                                last
);

  localparam int L = ANGLE_STAGES + 3;

  logic            to_cyl;
  logic            pts_cart;
  logic [L-1:0]    vld;
  logic [L-1:0]    rdy;
  ccvr_pkg::work_t w [ANGLE_STAGES+1];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      to_cyl   <= 1'b1;
      pts_cart <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccvr_pkg::CFG_TO_CYL:   to_cyl   <= cfg_data;
        ccvr_pkg::CFG_PTS_CART: pts_cart <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage advance chain
  always_comb begin
    rdy[L-1] = !vld[L-1] || !out_stall;
    for (int k = L - 2; k >= 0; k--) rdy[k] = !vld[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int k = 1; k < L; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[L-1];

  // input conditioning
  ccvr_pre u_pre (
    .clk          (clk),
    .en           (rdy[0]),
    .pts_cart     (pts_cart),
    .point_first  (point_first),
    .point_second (point_second),
    .vec_a        (vec_a),
    .vec_b        (vec_b),
    .vec_c        (vec_c),
    .last_point   (last_point),
    .q            (w[0])
  );

  // micro-rotation stages
  for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_stage
    ccvr_stage #(.IDX(i)) u_stage (
      .clk    (clk),
      .en     (rdy[i+1]),
      .to_cyl (to_cyl),
      .d      (w[i]),
      .q      (w[i+1])
    );
  end

  // gain, rounding, saturation
  ccvr_finish #(.ANGLE_STAGES(ANGLE_STAGES)) u_finish (
    .clk    (clk),
    .en_mul (rdy[L-2]),
    .en_out (rdy[L-1]),
    .d      (w[ANGLE_STAGES]),
    .res_a  (res_a),
    .res_b  (res_b),
    .res_c  (res_c),
    .last   (last)
  );

endmodule
